// ===== rtl/core/ordered_list_insert_erase_core_assert.svh =====
// Assertion macros for the ordered list core.
`ifndef ORDERED_LIST_INSERT_ERASE_CORE_ASSERT_SVH
`define ORDERED_LIST_INSERT_ERASE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define OLIE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ordered list core: assertion failed");
`define OLIE_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("ordered list core: reset assertion failed");
`else
`define OLIE_ASSERT(name, prop)
`define OLIE_ASSERT_RST(name, prop)
`endif
`endif

// ===== rtl/core/olie_pkg.sv =====
// Package with types and constants shared by the ordered list core and its cells.
package olie_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW = 9;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [DataW-1:0] data_t;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK = 3'd0,
    CMD_POP_BACK  = 3'd1,
    CMD_INSERT    = 3'd2,
    CMD_ERASE     = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_FILL      = 3'd5,
    CMD_READ      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_OPEN,
    CELL_CLOSE,
    CELL_FILL
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    pos_t     at;
    data_t    value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/olie_cell.sv =====
// One list cell: holds one entry and loads it from the command or a neighbor.
module olie_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                clk_i,
  input  olie_pkg::cell_ctrl_t ctrl_i,
  input  olie_pkg::data_t     left_i,
  input  olie_pkg::data_t     right_i,
  output olie_pkg::data_t     value_o
);

  localparam olie_pkg::pos_t MyPos = olie_pkg::PosW'(POS);

  olie_pkg::data_t value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      olie_pkg::CELL_LOAD: begin
        if (MyPos == ctrl_i.at) value_d = ctrl_i.value;
      end
      olie_pkg::CELL_OPEN: begin
        if (MyPos == ctrl_i.at) begin
          value_d = ctrl_i.value;
        end else if (MyPos > ctrl_i.at) begin
          value_d = left_i;
        end
      end
      olie_pkg::CELL_CLOSE: begin
        if (MyPos >= ctrl_i.at) value_d = right_i;
      end
      olie_pkg::CELL_FILL: begin
        if (MyPos < ctrl_i.at) value_d = ctrl_i.value;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== rtl/core/ordered_list_insert_erase_core.sv =====
// Ordered list core: a row of shifting cells with a command decoder and result register.
// A request accepted at a clock edge gives its result strobe in the next cycle.
// Throughput: one request per cycle; busy never rises, since the whole cell row updates
// in the cycle after the request.
// Reset clears the count, so the list is empty; stored entries keep no reset value.
// The result strobe is low during and right after reset.
`include "ordered_list_insert_erase_core_assert.svh"

module ordered_list_insert_erase_core #(
  parameter int unsigned CAPACITY = olie_pkg::DefaultCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic [4:0]         index_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o,
  output logic signed [31:0] read_value_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam olie_pkg::pos_t CapPos = olie_pkg::PosW'(CAPACITY);

  logic [CntW-1:0]      count_q, count_d;
  logic                 done_q;
  olie_pkg::status_e    status_q, status_d;
  olie_pkg::data_t      rd_q, rd_d;
  olie_pkg::cell_ctrl_t ctrl;
  olie_pkg::data_t      cell_val [CAPACITY];
  olie_pkg::cmd_e       cmd;
  olie_pkg::pos_t       idx_p, cnt_p;
  logic [AddrW-1:0]     rd_addr;
  logic                 accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign cmd    = olie_pkg::cmd_e'(command_i);
  assign idx_p  = olie_pkg::PosW'(index_i);
  assign cnt_p  = olie_pkg::PosW'(count_q);
  assign rd_addr = AddrW'(idx_p);

  always_comb begin
    status_d   = olie_pkg::ST_OK;
    count_d    = count_q;
    rd_d       = '0;
    ctrl.op    = olie_pkg::CELL_HOLD;
    ctrl.at    = idx_p;
    ctrl.value = value_i;
    unique case (cmd)
      olie_pkg::CMD_PUSH_BACK: begin
        if (cnt_p >= CapPos) begin
          status_d = olie_pkg::ST_FULL;
        end else begin
          ctrl.op = olie_pkg::CELL_LOAD;
          ctrl.at = cnt_p;
          count_d = count_q + CntW'(1);
        end
      end
      olie_pkg::CMD_POP_BACK: begin
        if (count_q == '0) begin
          status_d = olie_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      olie_pkg::CMD_INSERT: begin
        if (idx_p > cnt_p) begin
          status_d = olie_pkg::ST_BAD_INDEX;
        end else if (cnt_p >= CapPos) begin
          status_d = olie_pkg::ST_FULL;
        end else begin
          ctrl.op = olie_pkg::CELL_OPEN;
          count_d = count_q + CntW'(1);
        end
      end
      olie_pkg::CMD_ERASE: begin
        if (count_q == '0) begin
          status_d = olie_pkg::ST_EMPTY;
        end else if (idx_p >= cnt_p) begin
          status_d = olie_pkg::ST_BAD_INDEX;
        end else begin
          ctrl.op = olie_pkg::CELL_CLOSE;
          count_d = count_q - CntW'(1);
        end
      end
      olie_pkg::CMD_CLEAR: begin
        count_d = '0;
      end
      olie_pkg::CMD_FILL: begin
        if (idx_p > CapPos) begin
          status_d = olie_pkg::ST_FULL;
        end else begin
          ctrl.op = olie_pkg::CELL_FILL;
          count_d = CntW'(idx_p);
        end
      end
      olie_pkg::CMD_READ: begin
        if (count_q == '0) begin
          status_d = olie_pkg::ST_EMPTY;
        end else if (idx_p >= cnt_p) begin
          status_d = olie_pkg::ST_BAD_INDEX;
        end else begin
          rd_d = cell_val[rd_addr];
        end
      end
      default: status_d = olie_pkg::ST_OK;
    endcase
    if (!accept) ctrl.op = olie_pkg::CELL_HOLD;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    olie_pkg::data_t left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    olie_cell #(
      .POS(g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_val[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_q     <= rd_d;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign count_o      = 5'(count_q);
  assign read_value_o = rd_q;

  `OLIE_ASSERT(a_done_follows_request, (start && !busy) |=> done_o)
  `OLIE_ASSERT(a_no_spurious_done, !(start && !busy) |=> !done_o)
  `OLIE_ASSERT(a_count_in_range, CntW'(CAPACITY) >= count_q)
  `OLIE_ASSERT(a_read_value_zero, (accept && cmd != olie_pkg::CMD_READ) |=> (rd_q == '0))
  `OLIE_ASSERT_RST(a_reset_no_done, !rst_ni |=> !done_q)

endmodule
